@@ src/upwind_advection_step_2d_assert.svh @@
// Assertion macros shared by the upwind advection block.
// All of them sample on i_clk and are disabled while i_rst_n is low.
`ifndef UPWIND_ADVECTION_STEP_2D_ASSERT_SVH
`define UPWIND_ADVECTION_STEP_2D_ASSERT_SVH

// ante implies cons in the same cycle
`define UAS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uas assertion failed");

// cond must never hold
`define UAS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("uas assertion failed");

`endif

@@ src/uas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_pkg
// Constants and types of the 2D first-order upwind advection step.
// ----------------------------------------------------------------------------
package uas_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int LINE_DEPTH = MAX_WIDTH + 2;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // position counters reach dim+2
    localparam int POS_W      = $clog2(MAX_DIM + 3);

    localparam int CELL_W     = 32;
    localparam int DIFF_W     = CELL_W + 1;
    localparam int CFL_W      = 18;
    localparam int DIM_W      = 11;
    localparam int PROD_W     = CFL_W + DIFF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_W     = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // queue depth, power of two
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int CNT_W      = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COURANT_X   = 8'd0,
        REG_COURANT_Y   = 8'd1,
        REG_GRID_WIDTH  = 8'd2,
        REG_GRID_HEIGHT = 8'd3
    } t_reg_idx;

    // configuration as seen by the datapath, dimensions already clamped
    typedef struct packed {
        logic signed [CFL_W-1:0] cx;
        logic signed [CFL_W-1:0] cy;
        logic [POS_W-1:0]        width;
        logic [POS_W-1:0]        height;
    } t_cfg;

    // one classified stencil operation
    typedef struct packed {
        logic signed [CELL_W-1:0] u;
        logic signed [DIFF_W-1:0] dxt;
        logic signed [DIFF_W-1:0] dyt;
        logic                     last;
    } t_op;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_q_stat;

endpackage

@@ src/uas_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_if
// Valid/ready channels of the upwind advection block: cells in, results out,
// register writes.
// ----------------------------------------------------------------------------
interface uas_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [uas_pkg::CELL_W-1:0]  cell_value;
    logic                               frame_start;

    modport source (output valid, output cell_value, output frame_start, input ready);
    modport sink   (input valid, input cell_value, input frame_start, output ready);
endinterface

interface uas_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [uas_pkg::CELL_W-1:0]  new_value;
    logic                               last_of_frame;

    modport source (output valid, output new_value, output last_of_frame, input ready);
    modport sink   (input valid, input new_value, input last_of_frame, output ready);
endinterface

interface uas_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [uas_pkg::CFG_IDX_W-1:0]      index;
    logic [uas_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/uas_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_ram
// Simple dual-port RAM, one write and one registered read; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module uas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1026
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/uas_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_front
// Position tracking, line buffers and stencil window; classifies each cell
// and pushes the upwind differences of interior cells into the queue.
// ----------------------------------------------------------------------------
`include "upwind_advection_step_2d_assert.svh"

module uas_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  uas_pkg::t_cfg   i_cfg,
    input  uas_pkg::t_q_stat i_q_stat,
    uas_in_if.sink          i_cell,
    output logic            o_push,
    output uas_pkg::t_op    o_op
);

    localparam int POS_W  = uas_pkg::POS_W;
    localparam int SLOT_W = uas_pkg::SLOT_W;
    localparam int CELL_W = uas_pkg::CELL_W;
    localparam int DIFF_W = uas_pkg::DIFF_W;
    localparam int CNT_W  = uas_pkg::CNT_W;

    logic [POS_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_row, n_row;
    logic [POS_W-1:0]  c_cur, r_cur;
    logic [POS_W:0]    c_inc;
    logic [POS_W:0]    w_p1, w_p2, h_p1, h_p2;
    logic              accept;
    logic              emit, last;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W:0]    occupancy;

    // stage 2: line buffer data has returned
    logic              r_s2_vld;
    logic [SLOT_W-1:0] r_s2_slot;
    logic [CELL_W-1:0] r_s2_cell;
    logic              r_s2_emit;
    logic              r_s2_last;

    // older-row write of last cycle, for a same-slot read right behind it
    logic              r_fwd_vld;
    logic [SLOT_W-1:0] r_fwd_slot;
    logic [CELL_W-1:0] r_fwd_data;

    logic [CELL_W-1:0] older_rd, newer_rd, older_val;

    // window taps the stencil reads: top newest, centre, middle newest, bottom newest
    logic signed [CELL_W-1:0] r_win_top, r_win_ctr, r_win_mid, r_win_bot;
    logic signed [CELL_W-1:0] u, left, right, below, above;

    // room for the item in stage 2 and this one
    assign occupancy    = {1'b0, i_q_stat.count} + (CNT_W+1)'(r_s2_vld);
    assign i_cell.ready = occupancy < (CNT_W+1)'(uas_pkg::Q_DEPTH);
    assign accept       = i_cell.valid && i_cell.ready;

    always_comb begin
        c_cur = i_cell.frame_start ? '0 : r_col;
        r_cur = i_cell.frame_start ? '0 : r_row;
        w_p1  = {1'b0, i_cfg.width} + (POS_W+1)'(1);
        w_p2  = {1'b0, i_cfg.width} + (POS_W+1)'(2);
        h_p1  = {1'b0, i_cfg.height} + (POS_W+1)'(1);
        h_p2  = {1'b0, i_cfg.height} + (POS_W+1)'(2);
        emit  = ({1'b0, r_cur} >= (POS_W+1)'(2)) && ({1'b0, r_cur} <= h_p1) &&
                ({1'b0, c_cur} >= (POS_W+1)'(2)) && ({1'b0, c_cur} <= w_p1);
        last  = ({1'b0, r_cur} == h_p1) && ({1'b0, c_cur} == w_p1);
        // column never passes width+1, so it always names a slot
        slot  = c_cur[SLOT_W-1:0];
        c_inc = {1'b0, c_cur} + (POS_W+1)'(1);
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (c_inc >= w_p2) begin
                n_col = '0;
                n_row = ({1'b0, r_cur} < h_p2) ? r_cur + POS_W'(1) : r_cur;
            end else begin
                n_col = c_inc[POS_W-1:0];
                n_row = r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s2_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_s2_vld  <= accept;
            r_fwd_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_slot <= slot;
            r_s2_cell <= i_cell.cell_value;
            r_s2_emit <= emit;
            r_s2_last <= last;
        end
        r_fwd_slot <= r_s2_slot;
        r_fwd_data <= newer_rd;
    end

    uas_ram #(
        .WIDTH (CELL_W),
        .DEPTH (uas_pkg::LINE_DEPTH)
    ) u_row_newer (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (slot),
        .i_wdata (i_cell.cell_value),
        .i_re    (accept),
        .i_raddr (slot),
        .o_rdata (newer_rd)
    );

    uas_ram #(
        .WIDTH (CELL_W),
        .DEPTH (uas_pkg::LINE_DEPTH)
    ) u_row_older (
        .i_clk   (i_clk),
        .i_we    (r_s2_vld),
        .i_waddr (r_s2_slot),
        .i_wdata (newer_rd),
        .i_re    (accept),
        .i_raddr (slot),
        .o_rdata (older_rd)
    );

    assign older_val = (r_fwd_vld && (r_fwd_slot == r_s2_slot)) ? r_fwd_data : older_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_top <= '0;
            r_win_ctr <= '0;
            r_win_mid <= '0;
            r_win_bot <= '0;
        end else if (r_s2_vld) begin
            r_win_top <= older_val;
            r_win_ctr <= r_win_mid;
            r_win_mid <= newer_rd;
            r_win_bot <= r_s2_cell;
        end
    end

    // stencil around the centre after this shift
    always_comb begin
        u     = r_win_mid;
        left  = r_win_ctr;
        right = newer_rd;
        below = r_win_top;
        above = r_win_bot;
        o_op.u    = u;
        o_op.dxt  = i_cfg.cx[uas_pkg::CFL_W-1] ? (DIFF_W'(right) - DIFF_W'(u))
                                                : (DIFF_W'(u) - DIFF_W'(left));
        o_op.dyt  = i_cfg.cy[uas_pkg::CFL_W-1] ? (DIFF_W'(above) - DIFF_W'(u))
                                                : (DIFF_W'(u) - DIFF_W'(below));
        o_op.last = r_s2_last;
    end

    assign o_push = r_s2_vld && r_s2_emit;

    // back-to-back reads of one slot only happen on a frame restart at column zero
    `UAS_ASSERT_IMP(a_fwd_slot_zero, r_s2_vld && r_fwd_vld && r_fwd_slot == r_s2_slot, r_s2_slot == '0)
    `UAS_ASSERT_IMP(a_last_is_emit, r_s2_vld && r_s2_last, r_s2_emit)

endmodule

@@ src/uas_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_queue
// Short FIFO of stencil operations between front and back.
// ----------------------------------------------------------------------------
`include "upwind_advection_step_2d_assert.svh"

module uas_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  uas_pkg::t_op     i_op,
    input  logic             i_pop,
    output logic             o_valid,
    output uas_pkg::t_op     o_op,
    output uas_pkg::t_q_stat o_stat
);

    localparam int Q_AW  = uas_pkg::Q_AW;
    localparam int CNT_W = uas_pkg::CNT_W;

    uas_pkg::t_op     r_mem [uas_pkg::Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_valid      = r_cnt != '0;
    assign o_op         = r_mem[r_rd_ptr];
    assign o_stat.count = r_cnt;

    `UAS_ASSERT_IMP(a_no_overflow, i_push, r_cnt != CNT_W'(uas_pkg::Q_DEPTH) || i_pop)
    `UAS_ASSERT_NEVER(a_no_underflow, i_pop && r_cnt == '0)

endmodule

@@ src/uas_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uas_back
// Courant products, round to nearest and saturation; drives the result
// channel through an output register.
// ----------------------------------------------------------------------------
module uas_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uas_pkg::t_cfg i_cfg,
    input  logic          i_op_vld,
    input  uas_pkg::t_op  i_op,
    output logic          o_pop,
    uas_out_if.source     o_result
);

    localparam int CELL_W = uas_pkg::CELL_W;
    localparam int PROD_W = uas_pkg::PROD_W;
    localparam int ACC_W  = uas_pkg::ACC_W;
    localparam int FRAC_W = uas_pkg::FRAC_W;

    logic                     p_take, o_take;

    logic                     r_p_vld;
    logic signed [PROD_W-1:0] r_px, r_py;
    logic signed [CELL_W-1:0] r_pu;
    logic                     r_p_last;

    logic signed [ACC_W-1:0]  acc;
    logic                     ovf;
    logic signed [CELL_W-1:0] sat;

    logic                     r_o_vld;
    logic signed [CELL_W-1:0] r_o_val;
    logic                     r_o_last;

    assign o_take = !r_o_vld || o_result.ready;
    assign p_take = !r_p_vld || o_take;
    assign o_pop  = i_op_vld && p_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (p_take) begin
                r_p_vld <= o_pop;
            end
            if (o_take) begin
                r_o_vld <= r_p_vld;
            end
        end
    end

    // exact Q.32 products
    always_ff @(posedge i_clk) begin
        if (p_take) begin
            r_px     <= PROD_W'(i_cfg.cx) * PROD_W'(i_op.dxt);
            r_py     <= PROD_W'(i_cfg.cy) * PROD_W'(i_op.dyt);
            r_pu     <= i_op.u;
            r_p_last <= i_op.last;
        end
    end

    // u*2^16 - products + half, then floor to Q16.16
    always_comb begin
        acc = (ACC_W'(r_pu) <<< FRAC_W) - ACC_W'(r_px) - ACC_W'(r_py)
              + ACC_W'(1 << (FRAC_W - 1));
        ovf = (acc[ACC_W-1:FRAC_W+CELL_W-1] != '0) &&
              (acc[ACC_W-1:FRAC_W+CELL_W-1] != '1);
        if (ovf) begin
            sat = acc[ACC_W-1] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
        end else begin
            sat = acc[FRAC_W+CELL_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_o_val  <= sat;
            r_o_last <= r_p_last;
        end
    end

    assign o_result.valid         = r_o_vld;
    assign o_result.new_value     = r_o_val;
    assign o_result.last_of_frame = r_o_last;

endmodule

@@ src/upwind_advection_step_2d.sv @@
`timescale 1ns / 1ps
// Results follow the cell diagonally past them via stage 2, queue, products, output.
// Throughput: one cell per cycle unless the queue is near full; set by the line buffer
//   read/write ports and the two Courant multipliers, each used once per cell.
// Reset (sync, active low): position counters, window and queue cleared; Courant
//   numbers zero, grid 64 x 64. Line buffers are not cleared: no sweep, usable at once.
// ----------------------------------------------------------------------------
// upwind_advection_step_2d
// One first-order upwind time step of 2D linear advection on a streamed,
// halo-padded Q16.16 grid.
// ----------------------------------------------------------------------------
module upwind_advection_step_2d (
    input  logic      i_clk,
    input  logic      i_rst_n,
    uas_in_if.sink    i_cell,
    uas_cfg_if.sink   i_cfg,
    uas_out_if.source o_result
);

    localparam int CFL_W = uas_pkg::CFL_W;
    localparam int DIM_W = uas_pkg::DIM_W;
    localparam int POS_W = uas_pkg::POS_W;

    // ------------------------------------------------------------------
    // Register file. Writes are taken every cycle; unknown indexes drop.
    // ------------------------------------------------------------------
    logic signed [CFL_W-1:0] r_courant_x;
    logic signed [CFL_W-1:0] r_courant_y;
    logic [DIM_W-1:0]        r_grid_width;
    logic [DIM_W-1:0]        r_grid_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_courant_x   <= '0;
            r_courant_y   <= '0;
            r_grid_width  <= DIM_W'(64);
            r_grid_height <= DIM_W'(64);
        end else if (i_cfg.valid) begin
            case (uas_pkg::t_reg_idx'(i_cfg.index))
                uas_pkg::REG_COURANT_X:   r_courant_x   <= i_cfg.data[CFL_W-1:0];
                uas_pkg::REG_COURANT_Y:   r_courant_y   <= i_cfg.data[CFL_W-1:0];
                uas_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg.data[DIM_W-1:0];
                uas_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Dimensions in use are clamped to [1, max]; zero counts as one.
    // ------------------------------------------------------------------
    uas_pkg::t_cfg cfg;

    always_comb begin
        cfg.cx = r_courant_x;
        cfg.cy = r_courant_y;
        if (r_grid_width == '0) begin
            cfg.width = POS_W'(1);
        end else if (32'(r_grid_width) > 32'(uas_pkg::MAX_WIDTH)) begin
            cfg.width = POS_W'(uas_pkg::MAX_WIDTH);
        end else begin
            cfg.width = POS_W'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            cfg.height = POS_W'(1);
        end else if (32'(r_grid_height) > 32'(uas_pkg::MAX_HEIGHT)) begin
            cfg.height = POS_W'(uas_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = POS_W'(r_grid_height);
        end
    end

    // ------------------------------------------------------------------
    // Front: counts positions, runs the two line buffers and the window,
    // and pushes upwind differences for interior cells. It stalls the
    // cell channel only when the queue could not take what is in flight.
    // ------------------------------------------------------------------
    logic             push;
    uas_pkg::t_op     push_op;
    uas_pkg::t_q_stat q_stat;

    uas_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .i_cell   (i_cell),
        .o_push   (push),
        .o_op     (push_op)
    );

    // ------------------------------------------------------------------
    // Queue decouples the front from output back-pressure.
    // ------------------------------------------------------------------
    logic         q_vld;
    uas_pkg::t_op q_op;
    logic         pop;

    uas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_valid (q_vld),
        .o_op    (q_op),
        .o_stat  (q_stat)
    );

    // ------------------------------------------------------------------
    // Back: multiply by Courant numbers, round once, saturate, register.
    // ------------------------------------------------------------------
    uas_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_op_vld (q_vld),
        .i_op     (q_op),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
